>>> rtl/core/rar_pkg.sv
// Package for rational_arith_reduce: codes, widths and the sequencer state type.
package rar_pkg;
  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned FW = 32;   // port width of operand fields

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_SEED,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN,
    S_OUT
  } state_t;
endpackage

>>> rtl/core/rar_divider.sv
// Restoring divider: one quotient bit per cycle over a 2*WIDTH-bit dividend.
module rar_divider #(
  parameter int unsigned WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2*WIDTH-1:0]   dividend,
  input  logic [2*WIDTH-1:0]   divisor,
  output logic                 done,
  output logic [2*WIDTH-1:0]   quotient,
  output logic [2*WIDTH-1:0]   remainder
);
  import rar_pkg::*;

  localparam int unsigned DW = 2 * WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  always_comb begin
    shifted = {rem, quo[DW-1]};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= CW'(DW);
      end else if (busy) begin
        if (trial[DW]) begin
          rem <= shifted[DW-1:0];
          quo <= {quo[DW-2:0], 1'b0};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without run");
  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider busy at done");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(start)) |-> cnt == '0 || $past(rst)) else $error("divider count left over");
`endif
endmodule

>>> rtl/core/rational_arith_reduce.sv
// Top level of rational_arith_reduce: signed fraction arithmetic reduced by GCD.
// Usage:
//   Request channel: req_valid/req_ready with req_type, a_num, a_den, b_num, b_den.
//   Only the low WIDTH bits of each operand are used, as two's complement.
//   Result channel: res_valid/res_ready with res_num, res_den, status.
//   One result per request. Status 0 ok, 1 zero denominator, 2 overflow;
//   on a nonzero status res_num and res_den are 0. A zero fraction is 0/1.
// Timing:
//   One request at a time; req_ready is high only while idle.
//   Cross products come from one shared WIDTH x WIDTH multiplier, one per
//   cycle (three for add and subtract, two otherwise). Euclid's GCD then runs
//   on a shared restoring divider, one division per remainder step; the
//   step count depends on the data (up to about 90 steps at WIDTH 32, none
//   for a zero numerator). Two more divisions by the GCD follow.
//   res_valid rises once the division of the denominator has finished and
//   S_FIN has registered the result and the range check; a zero
//   denominator skips the divider and answers straight from S_SUM.
// Reset: synchronous rst returns the sequencer to idle and drops res_valid.
// Stall: the result is held in its output register until res_ready; the
//   next request is taken in the cycle after it has gone.
module rational_arith_reduce #(
  parameter int unsigned WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            req_type,
  input  logic signed [rar_pkg::FW-1:0] a_num,
  input  logic signed [rar_pkg::FW-1:0] a_den,
  input  logic signed [rar_pkg::FW-1:0] b_num,
  input  logic signed [rar_pkg::FW-1:0] b_den,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic signed [rar_pkg::FW-1:0] res_num,
  output logic [rar_pkg::FW-2:0] res_den,
  output logic [1:0]            status
);
  import rar_pkg::*;

  localparam int unsigned DW = 2 * WIDTH;

  state_t state, state_next;

  // captured operands as sign and magnitude
  op_t              op;
  logic             an_s, ad_s, bn_s, bd_s;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;

  // products, sums and Euclid registers
  logic [DW-1:0] p0, p1;
  logic          p0_s, p1_s;
  logic [DW-1:0] num_m, den_m;
  logic          num_s, den_s;
  logic [DW-1:0] gx, gy;
  logic [DW-1:0] nq;

  // shared multiplier
  logic [WIDTH-1:0] mx, my;
  logic [DW-1:0]    mp;

  // divider hookup
  logic          dv_start, dv_done;
  logic [DW-1:0] dv_a, dv_b, dv_q, dv_r;

  function automatic logic [WIDTH-1:0] mag_of(input logic [FW-1:0] v);
    logic [WIDTH-1:0] u;
    u = v[WIDTH-1:0];
    return u[WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

  assign mp = DW'(mx) * DW'(my);

  always_comb begin
    mx = an_m;
    my = bd_m;
    unique case (state)
      S_MUL0: begin
        mx = an_m;
        my = (op == OP_MUL) ? bn_m : bd_m;
      end
      S_MUL1: begin
        mx = ad_m;
        my = (op == OP_DIV) ? bn_m : bd_m;
      end
      S_MUL2: begin
        mx = ad_m;
        my = bn_m;
      end
      default: begin
        mx = an_m;
        my = bd_m;
      end
    endcase
  end

  rar_divider #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  // reduced result and range check
  logic          rneg;
  logic [DW-1:0] lim;
  logic          ovf;
  always_comb begin
    lim  = DW'(1) << (WIDTH - 1);
    rneg = (num_s != den_s) && (nq != '0);
    ovf  = (dv_q > lim - 1'b1) || (rneg ? (nq > lim) : (nq > lim - 1'b1));
  end

  always_comb begin
    state_next = state;
    dv_start   = 1'b0;
    dv_a       = gx;
    dv_b       = gy;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_MUL0;
      S_MUL0:  state_next = S_MUL1;
      S_MUL1:  state_next = (op == OP_ADD || op == OP_SUB) ? S_MUL2 : S_SUM;
      S_MUL2:  state_next = S_SUM;
      S_SUM: begin
        if (den_m == '0) state_next = S_OUT;
        else             state_next = S_SEED;
      end
      // num_m and den_m are settled here for every operation
      S_SEED: begin
        dv_start = 1'b1;
        dv_a     = num_m;
        dv_b     = den_m;
        if (num_m == '0) state_next = S_DIVN;
        else             state_next = S_GCD;
      end
      S_GCD: begin
        if (dv_done) begin
          if (dv_r == '0) begin
            state_next = S_DIVN;
            dv_start   = 1'b1;
            dv_a       = num_m;
            dv_b       = gy;
          end else begin
            dv_start = 1'b1;
            dv_a     = gy;
            dv_b     = dv_r;
          end
        end
      end
      S_DIVN: begin
        if (dv_done) begin
          state_next = S_DIVD;
          dv_start   = 1'b1;
          dv_a       = den_m;
          dv_b       = gy;
        end
      end
      S_DIVD:  if (dv_done) state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT:   if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op   <= op_t'(req_type);
        an_s <= a_num[WIDTH-1];
        ad_s <= a_den[WIDTH-1];
        bn_s <= b_num[WIDTH-1] ^ (req_type == OP_SUB);
        bd_s <= b_den[WIDTH-1];
        an_m <= mag_of(a_num);
        ad_m <= mag_of(a_den);
        bn_m <= mag_of(b_num);
        bd_m <= mag_of(b_den);
      end
      S_MUL0: begin
        p0   <= mp;
        p0_s <= (op == OP_MUL) ? (an_s ^ bn_s) : (an_s ^ bd_s);
      end
      S_MUL1: begin
        if (op == OP_ADD || op == OP_SUB) begin
          den_m <= mp;
          den_s <= ad_s ^ bd_s;
        end else begin
          den_m <= mp;
          den_s <= (op == OP_DIV) ? (ad_s ^ bn_s) : (ad_s ^ bd_s);
          num_m <= p0;
          num_s <= p0_s;
        end
      end
      S_MUL2: begin
        p1   <= mp;
        p1_s <= ad_s ^ bn_s;
      end
      S_SUM: begin
        if (op == OP_ADD || op == OP_SUB) begin
          if (p0_s == p1_s) begin
            num_m <= p0 + p1;
            num_s <= p0_s;
          end else if (p0 >= p1) begin
            num_m <= p0 - p1;
            num_s <= p0_s;
          end else begin
            num_m <= p1 - p0;
            num_s <= p1_s;
          end
        end
      end
      S_SEED: begin
        gy <= den_m;
        gx <= num_m;
      end
      S_GCD: if (dv_done && dv_r != '0) begin
        gx <= gy;
        gy <= dv_r;
      end
      S_DIVN: if (dv_done) nq <= dv_q;
      S_FIN: begin
        if (ovf) begin
          res_num <= '0;
          res_den <= '0;
          status  <= ST_OVF;
        end else begin
          res_num <= FW'(signed'(rneg ? (WIDTH'(0) - nq[WIDTH-1:0]) : nq[WIDTH-1:0]));
          res_den <= (FW-1)'(dv_q[WIDTH-1:0]);
          status  <= ST_OK;
        end
      end
      default: ;
    endcase
    if (state == S_SUM && den_m == '0) begin
      res_num <= '0;
      res_den <= '0;
      status  <= ST_ZDEN;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !res_valid) else $error("ready while result pending");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(res_num) && $stable(status))
    else $error("result not held");
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_OK) |-> res_den != '0) else $error("zero den on ok");
`endif
endmodule
